@@ rtl/pic_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_pkg: shared types and constants for the clamped PI controller
// Register indexes, multiplier operand selects, datapath widths and the
// command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package pic_pkg;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int ERR_W    = SAMPLE_W + 1;
	localparam int INTEG_W  = 32;
	localparam int CFG_W    = 32;
	localparam int IDX_W    = 3;
	localparam int MUL_A_W  = 32;
	localparam int MUL_B_W  = 18;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int ACC_W    = INTEG_W + 2;
	localparam int P_W      = ERR_W + GAIN_W - 8;
	localparam int I_W      = INTEG_W + GAIN_W - 24;
	localparam int SUM_W    = P_W + 1;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
	localparam logic [IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd2;
	localparam logic [IDX_W-1:0] REG_INTEG_UPPER   = 3'd3;
	localparam logic [IDX_W-1:0] REG_INTEG_LOWER   = 3'd4;
	localparam logic [IDX_W-1:0] REG_DRIVE_UPPER   = 3'd5;
	localparam logic [IDX_W-1:0] REG_DRIVE_LOWER   = 3'd6;

	// input action codes
	localparam logic ACT_STEP  = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	// multiplier operand selects
	localparam logic [1:0] MUL_ERR_PERIOD = 2'd0;
	localparam logic [1:0] MUL_PGAIN_ERR  = 2'd1;
	localparam logic [1:0] MUL_IGAIN_INT  = 2'd2;

	typedef struct packed {
		logic       capture;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       integ_upd;
		logic       integ_clr;
		logic       p_load;
		logic       out_load;
		logic       out_zero;
	} pic_cmd_t;

endpackage

@@ rtl/pic_item_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_item_if: input channel of the PI controller
// Valid/ready channel carrying one action with its target and measured sample.
// ----------------------------------------------------------------------------
interface pic_item_if;
	logic                      valid;
	logic                      ready;
	logic                      action;
	logic signed [15:0]        target;
	logic signed [15:0]        measured;

	modport source (output valid, output action, output target, output measured, input ready);
	modport sink   (input valid, input action, input target, input measured, output ready);
endinterface

@@ rtl/pic_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_result_if: output channel of the PI controller
// Valid/ready channel carrying the clamped drive value.
// ----------------------------------------------------------------------------
interface pic_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink   (input valid, input drive, output ready);
endinterface

@@ rtl/pi_controller_clamped.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_controller_clamped: discrete PI controller with integral clamp
// Top level joining the sequencer and the datapath to the channels.
// ----------------------------------------------------------------------------
// A control step captures the error at acceptance, then makes three passes
// through the single shared 32x18 multiplier and forms the sum and clamp; a
// clear zeroes the integral and the drive. The block holds one item at a time
// and takes the next one in the cycle after the drive is registered; the drive
// is registered only once the output register is free of an untaken value.
// The drive waits in an output register while the next item is already being
// worked on. Configuration writes take effect at once and should be made while
// idle.
module pi_controller_clamped (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [pic_pkg::IDX_W-1:0] wr_index,
	input  logic [pic_pkg::CFG_W-1:0] wr_data,
	pic_item_if.sink                  item,
	pic_result_if.source              result
);
	import pic_pkg::*;

	pic_cmd_t cmd;

	pic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.action    (item.action),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	pic_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.target   (item.target),
		.measured (item.measured),
		.cmd      (cmd),
		.drive    (result.drive)
	);

endmodule

@@ rtl/pic_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_datapath: arithmetic of the clamped PI controller
// Configuration registers, error register, one shared 32x18 multiplier,
// integral accumulator with clamp, and the drive sum with output clamp.
// ----------------------------------------------------------------------------
module pic_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [pic_pkg::IDX_W-1:0]        wr_index,
	input  logic [pic_pkg::CFG_W-1:0]        wr_data,
	input  logic signed [pic_pkg::SAMPLE_W-1:0] target,
	input  logic signed [pic_pkg::SAMPLE_W-1:0] measured,
	input  pic_pkg::pic_cmd_t                cmd,
	output logic signed [pic_pkg::SAMPLE_W-1:0] drive
);
	import pic_pkg::*;

	logic signed [GAIN_W-1:0]   prop_gain_q;
	logic signed [GAIN_W-1:0]   integ_gain_q;
	logic [SAMPLE_W-1:0]        sample_period_q;
	logic signed [INTEG_W-1:0]  integ_upper_q;
	logic signed [INTEG_W-1:0]  integ_lower_q;
	logic signed [SAMPLE_W-1:0] drive_upper_q;
	logic signed [SAMPLE_W-1:0] drive_lower_q;

	logic signed [ERR_W-1:0]    err_q;
	logic signed [INTEG_W-1:0]  integ_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [P_W-1:0]      p_q;
	logic signed [SAMPLE_W-1:0] drive_q;

	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [ACC_W-1:0]    acc;
	logic signed [INTEG_W-1:0]  acc_clamped;
	logic signed [I_W-1:0]      i_term;
	logic signed [SUM_W-1:0]    sum;
	logic signed [SAMPLE_W-1:0] sum_clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q     <= '0;
			integ_gain_q    <= '0;
			sample_period_q <= '0;
			integ_upper_q   <= {1'b0, {(INTEG_W-1){1'b1}}};
			integ_lower_q   <= {1'b1, {(INTEG_W-1){1'b0}}};
			drive_upper_q   <= {1'b0, {(SAMPLE_W-1){1'b1}}};
			drive_lower_q   <= {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else if (wr_en) begin
			case (wr_index)
				REG_PROP_GAIN:     prop_gain_q     <= wr_data[GAIN_W-1:0];
				REG_INTEG_GAIN:    integ_gain_q    <= wr_data[GAIN_W-1:0];
				REG_SAMPLE_PERIOD: sample_period_q <= wr_data[SAMPLE_W-1:0];
				REG_INTEG_UPPER:   integ_upper_q   <= wr_data[INTEG_W-1:0];
				REG_INTEG_LOWER:   integ_lower_q   <= wr_data[INTEG_W-1:0];
				REG_DRIVE_UPPER:   drive_upper_q   <= wr_data[SAMPLE_W-1:0];
				REG_DRIVE_LOWER:   drive_lower_q   <= wr_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// shared multiplier operand mux
	always_comb begin
		case (cmd.mul_sel)
			MUL_ERR_PERIOD: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = $signed({{(MUL_B_W-SAMPLE_W){1'b0}}, sample_period_q});
			end
			MUL_PGAIN_ERR: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = MUL_B_W'(prop_gain_q);
			end
			MUL_IGAIN_INT: begin
				mul_a = integ_q;
				mul_b = MUL_B_W'(integ_gain_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// integral update: err * period fits in ACC_W - 1 bits
	always_comb begin
		acc = ACC_W'(integ_q) + $signed(prod_q[ACC_W-1:0]);
		if (acc > ACC_W'(integ_upper_q))
			acc_clamped = integ_upper_q;
		else if (acc < ACC_W'(integ_lower_q))
			acc_clamped = integ_lower_q;
		else
			acc_clamped = acc[INTEG_W-1:0];
	end

	// drive: p + (igain * integ) >>> 24, clamped
	always_comb begin
		i_term = $signed(prod_q[INTEG_W+GAIN_W-1:24]);
		sum    = SUM_W'(p_q) + SUM_W'(i_term);
		if (sum > SUM_W'(drive_upper_q))
			sum_clamped = drive_upper_q;
		else if (sum < SUM_W'(drive_lower_q))
			sum_clamped = drive_lower_q;
		else
			sum_clamped = sum[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (cmd.integ_clr) begin
			integ_q <= '0;
		end else if (cmd.integ_upd) begin
			integ_q <= acc_clamped;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			err_q <= ERR_W'(target) - ERR_W'(measured);
		if (cmd.mul_en)
			prod_q <= mul_a * mul_b;
		// pgain * err is 33 bits; keep bits above the Q8.8 fraction
		if (cmd.p_load)
			p_q <= $signed(prod_q[ERR_W+GAIN_W-1:8]);
		if (cmd.out_load)
			drive_q <= cmd.out_zero ? '0 : sum_clamped;
	end

	assign drive = drive_q;

endmodule

@@ rtl/pic_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_ctrl: sequencer of the clamped PI controller
// Steps an item through error capture, three shared multiplies, integral
// update and drive sum (a clear zeroes both); owns the output valid flag.
// ----------------------------------------------------------------------------
module pic_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              action,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output pic_pkg::pic_cmd_t cmd
);
	import pic_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_MUL_ERR = 3'd1;
	localparam logic [2:0] ST_ACC     = 3'd2;
	localparam logic [2:0] ST_MUL_INT = 3'd3;
	localparam logic [2:0] ST_SUM     = 3'd4;
	localparam logic [2:0] ST_CLR     = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = accept;
				if (accept)
					state_nxt = (action == ACT_CLEAR) ? ST_CLR : ST_MUL_ERR;
			end
			ST_MUL_ERR: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ERR_PERIOD;
				state_nxt   = ST_ACC;
			end
			ST_ACC: begin
				// integral takes err*period while the multiplier moves on
				cmd.integ_upd = 1'b1;
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MUL_PGAIN_ERR;
				state_nxt     = ST_MUL_INT;
			end
			ST_MUL_INT: begin
				cmd.p_load  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_IGAIN_INT;
				state_nxt   = ST_SUM;
			end
			ST_SUM: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			ST_CLR: begin
				if (out_free) begin
					cmd.integ_clr = 1'b1;
					cmd.out_load  = 1'b1;
					cmd.out_zero  = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
